### rtl/crf_pkg.sv
package crf_pkg;

  // default sizes
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // fixed field widths at the ports
  localparam int REQ_W    = 2;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // stream widths; tdata rounded up to whole bytes
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;
  localparam int M_USER_W = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_POP_RD,
    S_POP_CHK,
    S_CAN_RD,
    S_CAN_CHK,
    S_DONE
  } state_t;

endpackage

### rtl/crf_slot_ram.sv
module crf_slot_ram #(
  parameter int DEPTH = crf_pkg::DEPTH_DEF,
  parameter int WIDTH = crf_pkg::TAG_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cancellable_ring_fifo.sv
// channel | dir | tdata (low bit up)                 | tuser
// s_*     | in  | tag[15:0]                          | req_type[1:0]
// m_*     | out | out_tag[15:0], occupancy[20:16], 0 | status[1:0]
//
// one item at a time; the slot memory has one read and one write port and
// a registered read, so each slot visit is a read state and a check state
// append writes the tail unless full, no-op goes to done directly, pop
// consumes slots to the first live tag; cancel visits each occupied slot
// reset clears head, count and control; slot contents need no clearing
// the next item is taken once the result is in the output register
module cancellable_ring_fifo #(
  parameter int DEPTH    = crf_pkg::DEPTH_DEF,
  parameter int TAG_BITS = crf_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [crf_pkg::S_DATA_W-1:0]  s_tdata,  // tag[15:0]
  input  logic [crf_pkg::S_USER_W-1:0]  s_tuser,  // req_type[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [crf_pkg::M_DATA_W-1:0]  m_tdata,  // out_tag, occupancy, zero pad
  output logic [crf_pkg::M_USER_W-1:0]  m_tuser   // status[1:0]
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SB = (TAG_BITS < crf_pkg::TAG_W) ? TAG_BITS : crf_pkg::TAG_W;
  localparam int RW = SB + 1;

  crf_pkg::state_t state, state_next;

  logic [IW-1:0]                  head;
  logic [CW-1:0]                  fill;
  logic [IW-1:0]                  scan_idx;
  logic [CW-1:0]                  scan_cnt;
  logic [SB-1:0]                  tag_r;
  logic [crf_pkg::STATUS_W-1:0]   res_status;
  logic [crf_pkg::TAG_W-1:0]      res_tag;

  logic           ram_we, ram_re;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic           rd_live;
  logic [SB-1:0]  rd_tag;

  logic [IW:0]    tail_sum;
  logic [IW-1:0]  tail;
  logic [IW-1:0]  head_inc, scan_inc;
  logic           full, empty, scan_end, tag_hit, out_free;
  logic [31:0]    fill_ext;

  assign rd_live = ram_rdata[SB];
  assign rd_tag  = ram_rdata[SB-1:0];

  // index arithmetic with a single wrap
  assign tail_sum = (IW+1)'(head) + (IW+1)'(fill);
  assign tail     = (tail_sum >= (IW+1)'(DEPTH)) ? IW'(tail_sum - (IW+1)'(DEPTH))
                                                 : IW'(tail_sum);
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign scan_inc = (scan_idx == IW'(DEPTH - 1)) ? '0 : scan_idx + 1'b1;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign scan_end = (scan_cnt == fill);
  assign tag_hit  = rd_live && (rd_tag == tag_r);
  assign out_free = !m_tvalid || m_tready;
  assign fill_ext = 32'(fill);

  crf_slot_ram #(
    .DEPTH (DEPTH),
    .WIDTH (RW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      crf_pkg::S_IDLE: begin
        if (s_tvalid) begin
          unique case (crf_pkg::req_t'(s_tuser))
            crf_pkg::REQ_APPEND: state_next = crf_pkg::S_APPEND;
            crf_pkg::REQ_POP:    state_next = crf_pkg::S_POP_RD;
            crf_pkg::REQ_CANCEL: state_next = crf_pkg::S_CAN_RD;
            default:             state_next = crf_pkg::S_DONE;
          endcase
        end
      end
      crf_pkg::S_APPEND:  state_next = crf_pkg::S_DONE;
      crf_pkg::S_POP_RD:  state_next = empty ? crf_pkg::S_DONE : crf_pkg::S_POP_CHK;
      crf_pkg::S_POP_CHK: state_next = rd_live ? crf_pkg::S_DONE : crf_pkg::S_POP_RD;
      crf_pkg::S_CAN_RD:  state_next = scan_end ? crf_pkg::S_DONE : crf_pkg::S_CAN_CHK;
      crf_pkg::S_CAN_CHK: state_next = crf_pkg::S_CAN_RD;
      crf_pkg::S_DONE: begin
        if (out_free) begin
          state_next = crf_pkg::S_IDLE;
        end
      end
      default: state_next = crf_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = {1'b1, tag_r};
    ram_re    = 1'b0;
    ram_raddr = head;
    unique case (state)
      crf_pkg::S_IDLE: s_tready = 1'b1;
      crf_pkg::S_APPEND: begin
        ram_we = !full;
      end
      crf_pkg::S_POP_RD: begin
        ram_re = !empty;
      end
      crf_pkg::S_CAN_RD: begin
        ram_re    = !scan_end;
        ram_raddr = scan_idx;
      end
      crf_pkg::S_CAN_CHK: begin
        ram_we    = tag_hit;
        ram_waddr = scan_idx;
        ram_wdata = {1'b0, rd_tag};
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= crf_pkg::S_IDLE;
      head     <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        crf_pkg::S_APPEND: begin
          if (!full) begin
            fill <= fill + 1'b1;
          end
        end
        crf_pkg::S_POP_CHK: begin
          head <= head_inc;
          fill <= fill - 1'b1;
        end
        default: begin
        end
      endcase
      if (state == crf_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      crf_pkg::S_IDLE: begin
        tag_r      <= s_tdata[SB-1:0];
        res_status <= crf_pkg::ST_DONE;
        res_tag    <= '0;
        scan_idx   <= head;
        scan_cnt   <= '0;
      end
      crf_pkg::S_APPEND: begin
        if (full) begin
          res_status <= crf_pkg::ST_FULL;
        end
      end
      crf_pkg::S_POP_RD: begin
        if (empty) begin
          res_status <= crf_pkg::ST_EMPTY;
        end
      end
      crf_pkg::S_POP_CHK: begin
        if (rd_live) begin
          res_tag <= crf_pkg::TAG_W'(rd_tag);
        end
      end
      crf_pkg::S_CAN_CHK: begin
        scan_idx <= scan_inc;
        scan_cnt <= scan_cnt + 1'b1;
      end
      crf_pkg::S_DONE: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {3'b000, fill_ext[crf_pkg::OCC_W-1:0], res_tag};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### bench/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = crf_pkg::DEPTH_DEF;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    crf_pkg::req_t             kind;
    logic [crf_pkg::TAG_W-1:0] tag;
  } tag_req_t;

  typedef struct packed {
    logic [crf_pkg::STATUS_W-1:0] status;
    logic [crf_pkg::TAG_W-1:0]    out_tag;
    logic [crf_pkg::OCC_W-1:0]    occupancy;
  } fifo_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [crf_pkg::S_DATA_W-1:0] s_tdata = '0;  // tag[15:0]
  logic [crf_pkg::S_USER_W-1:0] s_tuser = '0;  // req_type[1:0]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [crf_pkg::M_DATA_W-1:0] m_tdata;  // out_tag[15:0], occupancy[20:16], zero pad
  logic [crf_pkg::M_USER_W-1:0] m_tuser;  // status[1:0]

  // items waiting to be sent and results still owed by the block
  tag_req_t     req_queue[$];
  fifo_result_t awaited_results[$];
  int           err_count = 0;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;

  // shadow copy of the ring
  logic [crf_pkg::TAG_W-1:0] ring_tags[RING_DEPTH];
  logic                      ring_live[RING_DEPTH];
  int                        ring_head = 0;
  int                        ring_count = 0;

  logic [crf_pkg::TAG_W-1:0] tag_pool[4];

  cancellable_ring_fifo i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the shadow ring and return the result it must give
  function automatic fifo_result_t ring_fifo_step(tag_req_t req);
    fifo_result_t res;
    logic found;
    int idx;
    res.status = crf_pkg::ST_DONE;
    res.out_tag = '0;
    res.occupancy = '0;
    found = 1'b0;
    case (req.kind)
      crf_pkg::REQ_APPEND: begin
        if (ring_count >= RING_DEPTH) begin
          res.status = crf_pkg::ST_FULL;
        end else begin
          idx = (ring_head + ring_count) % RING_DEPTH;
          ring_tags[idx] = req.tag;
          ring_live[idx] = 1'b1;
          ring_count++;
        end
      end
      crf_pkg::REQ_POP: begin
        // cancelled slots are consumed on the way to a live one
        while (!found && ring_count > 0) begin
          if (ring_live[ring_head]) begin
            found = 1'b1;
            res.out_tag = ring_tags[ring_head];
          end
          ring_live[ring_head] = 1'b0;
          ring_head = (ring_head + 1) % RING_DEPTH;
          ring_count--;
        end
        if (!found) res.status = crf_pkg::ST_EMPTY;
      end
      crf_pkg::REQ_CANCEL: begin
        for (int k = 0; k < ring_count; k++) begin
          idx = (ring_head + k) % RING_DEPTH;
          if (ring_live[idx] && ring_tags[idx] == req.tag) ring_live[idx] = 1'b0;
        end
      end
      default: ;
    endcase
    res.occupancy = ring_count[crf_pkg::OCC_W-1:0];
    return res;
  endfunction

  // random request; fill-heavy or drain-heavy mix, tags mostly from a small pool
  function automatic tag_req_t random_req(logic fill_bias);
    tag_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    if (fill_bias)
      req.kind = crf_pkg::req_t'((pick < 60) ? crf_pkg::REQ_APPEND :
                                 (pick < 80) ? crf_pkg::REQ_POP :
                                 (pick < 95) ? crf_pkg::REQ_CANCEL : crf_pkg::REQ_NOP);
    else
      req.kind = crf_pkg::req_t'((pick < 25) ? crf_pkg::REQ_APPEND :
                                 (pick < 75) ? crf_pkg::REQ_POP :
                                 (pick < 95) ? crf_pkg::REQ_CANCEL : crf_pkg::REQ_NOP);
    if ($urandom_range(0, 3) != 0) req.tag = tag_pool[$urandom_range(0, 3)];
    else req.tag = crf_pkg::TAG_W'($urandom_range(0, 65535));
    return req;
  endfunction

  // driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    tag_req_t sent;
    tag_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sent.kind = crf_pkg::req_t'(s_tuser);
        sent.tag = s_tdata[crf_pkg::TAG_W-1:0];
        awaited_results.push_back(ring_fifo_step(sent));
      end
      if (!s_tvalid || s_tready) begin
        if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.tag;
          s_tuser <= nxt.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d out_tag %h occupancy %0d",
                 m_tuser, m_tdata[15:0], m_tdata[20:16]);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            err_count++;
          end
          if (m_tdata[15:0] !== want.out_tag) begin
            $error("out_tag: expected %h, actual %h", want.out_tag, m_tdata[15:0]);
            err_count++;
          end
          if (m_tdata[20:16] !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy,
                   m_tdata[20:16]);
            err_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // stimulus and end of run
  initial begin
    tag_req_t req;
    logic fill_bias;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_live[i] = 1'b0;
      ring_tags[i] = '0;
    end
    for (int i = 0; i < 4; i++) tag_pool[i] = crf_pkg::TAG_W'($urandom_range(0, 65535));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, no-op, cancel on empty, fill past full,
    // cancels that kill every slot but one, pops over cancelled slots
    req_queue.push_back('{crf_pkg::REQ_POP, 16'h0000});
    req_queue.push_back('{crf_pkg::REQ_NOP, 16'hffff});
    req_queue.push_back('{crf_pkg::REQ_CANCEL, 16'h1234});
    req_queue.push_back('{crf_pkg::REQ_APPEND, 16'h0000});
    req_queue.push_back('{crf_pkg::REQ_APPEND, 16'hffff});
    for (int i = 0; i < RING_DEPTH - 2; i++)
      req_queue.push_back('{crf_pkg::REQ_APPEND, 16'ha5a5});
    req_queue.push_back('{crf_pkg::REQ_APPEND, 16'h5a5a});
    req_queue.push_back('{crf_pkg::REQ_CANCEL, 16'hffff});
    req_queue.push_back('{crf_pkg::REQ_CANCEL, 16'ha5a5});
    req_queue.push_back('{crf_pkg::REQ_POP, 16'hffff});
    req_queue.push_back('{crf_pkg::REQ_POP, 16'h0000});

    // three phases of random traffic, the first two with send gaps and receive stalls
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct <= (phase == 0) ? 37 : (phase == 1) ? 79 : 0;
      recv_stall_pct <= (phase == 0) ? 79 : (phase == 1) ? 37 : 0;
      fill_bias = 1'b1;
      for (int i = 0; i < 410; i++) begin
        if (i % 24 == 0) fill_bias = 1'($urandom_range(0, 1));
        req = random_req(fill_bias);
        req_queue.push_back(req);
      end
      while (req_queue.size() != 0) @(negedge clk);
    end

    while (s_tvalid || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
